// File: hdl/rhc_pkg.sv
package rhc_pkg;

	localparam int CH_W            = 8;
	localparam int NUM_W           = 11;
	localparam int HDVD_W          = NUM_W + CH_W;
	localparam int HDVS_W          = NUM_W;
	localparam int SDVD_W          = 2 * CH_W;
	localparam int Q_W             = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one classified pixel: two division problems plus value
	typedef struct packed {
		logic [HDVD_W-1:0] hue_dvd;
		logic [HDVS_W-1:0] hue_dvs;
		logic [SDVD_W-1:0] sat_dvd;
		logic [CH_W-1:0]   sat_dvs;
		logic [CH_W-1:0]   value;
	} job_t;

	// divider pipeline state
	typedef struct packed {
		logic [HDVD_W-1:0] hue_rem;
		logic [HDVS_W-1:0] hue_dvs;
		logic [Q_W-1:0]    hue_q;
		logic [SDVD_W-1:0] sat_rem;
		logic [CH_W-1:0]   sat_dvs;
		logic [Q_W-1:0]    sat_q;
		logic [CH_W-1:0]   value;
	} div_t;

endpackage

// File: hdl/rhc_front.sv
module rhc_front
	import rhc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  logic [CH_W-1:0] red_in,
	input  logic [CH_W-1:0] green_in,
	input  logic [CH_W-1:0] blue_in,
	output logic            job_valid,
	input  logic            job_ready,
	output job_t            job
);

	sector_t            sector;
	logic [CH_W-1:0]    mx;
	logic [CH_W-1:0]    mn;
	logic [CH_W-1:0]    chroma;
	logic [NUM_W-1:0]   r11;
	logic [NUM_W-1:0]   g11;
	logic [NUM_W-1:0]   b11;
	logic [NUM_W-1:0]   c11;
	logic [NUM_W-1:0]   c6;
	logic [NUM_W-1:0]   num;
	logic [HDVD_W-1:0]  num_w;
	logic [SDVD_W-1:0]  c16;
	job_t               job_d;
	logic               vld_s1;
	job_t               job_s1;

	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			sector = SEC_RED;
			mx     = red_in;
		end else if (green_in >= blue_in) begin
			sector = SEC_GREEN;
			mx     = green_in;
		end else begin
			sector = SEC_BLUE;
			mx     = blue_in;
		end
		mn = (red_in < green_in) ? red_in : green_in;
		if (blue_in < mn) begin
			mn = blue_in;
		end
		chroma = mx - mn;
		r11    = NUM_W'(red_in);
		g11    = NUM_W'(green_in);
		b11    = NUM_W'(blue_in);
		c11    = NUM_W'(chroma);
		c6     = (c11 << 2) + (c11 << 1);
		unique case (sector)
			SEC_RED: begin
				num = (green_in >= blue_in) ? (g11 - b11) : (c6 - (b11 - g11));
			end
			SEC_GREEN: begin
				num = (c11 << 1) + b11 - r11;
			end
			SEC_BLUE: begin
				num = (c11 << 2) + r11 - g11;
			end
			default: begin
				num = '0;
			end
		endcase
		num_w         = HDVD_W'(num);
		c16           = SDVD_W'(chroma);
		job_d.hue_dvd = (num_w << 8) - num_w;
		job_d.hue_dvs = (chroma == '0) ? HDVS_W'(1) : c6;
		job_d.sat_dvd = (c16 << 8) - c16;
		job_d.sat_dvs = (mx == '0) ? CH_W'(1) : mx;
		job_d.value   = mx;
	end

	assign pix_ready = !vld_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix_ready) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			job_s1 <= job_d;
		end
	end

	assign job_valid = vld_s1;
	assign job       = job_s1;

endmodule

// File: hdl/rhc_queue.sv
module rhc_queue
	import rhc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: hdl/rhc_div_pipe.sv
module rhc_div_pipe
	import rhc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  job_t            job,
	output logic            hsv_valid,
	input  logic            hsv_ready,
	output logic [Q_W-1:0]  hue_out,
	output logic [Q_W-1:0]  saturation_out,
	output logic [CH_W-1:0] value_out
);

	// one quotient bit per stage, MSB first, for both divisions in parallel
	div_t         div_s [Q_W];
	logic [Q_W-1:0] vld_s;
	logic [Q_W-1:0] rdy;
	logic [Q_W-1:0] src_v;
	div_t         src [Q_W];
	div_t         nxt [Q_W];

	always_comb begin
		src[0].hue_rem = job.hue_dvd;
		src[0].hue_dvs = job.hue_dvs;
		src[0].hue_q   = '0;
		src[0].sat_rem = job.sat_dvd;
		src[0].sat_dvs = job.sat_dvs;
		src[0].sat_q   = '0;
		src[0].value   = job.value;
		src_v[0]       = job_valid;
	end

	genvar j;
	generate
		for (j = 1; j < Q_W; j++) begin : g_src
			assign src[j]   = div_s[j-1];
			assign src_v[j] = vld_s[j-1];
		end
		for (j = 0; j < Q_W; j++) begin : g_step
			localparam int K = Q_W - 1 - j;
			logic [HDVD_W-1:0] hue_sh;
			logic [SDVD_W-1:0] sat_sh;
			always_comb begin
				hue_sh = HDVD_W'(src[j].hue_dvs) << K;
				sat_sh = SDVD_W'(src[j].sat_dvs) << K;
				nxt[j] = src[j];
				if (src[j].hue_rem >= hue_sh) begin
					nxt[j].hue_rem  = src[j].hue_rem - hue_sh;
					nxt[j].hue_q[K] = 1'b1;
				end
				if (src[j].sat_rem >= sat_sh) begin
					nxt[j].sat_rem  = src[j].sat_rem - sat_sh;
					nxt[j].sat_q[K] = 1'b1;
				end
			end
		end
	endgenerate

	always_comb begin
		rdy[Q_W-1] = !vld_s[Q_W-1] || hsv_ready;
		for (int i = Q_W - 2; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < Q_W; i++) begin
				if (rdy[i]) begin
					vld_s[i] <= src_v[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_W; i++) begin
			if (rdy[i] && src_v[i]) begin
				div_s[i] <= nxt[i];
			end
		end
	end

	assign job_ready      = rdy[0];
	assign hsv_valid      = vld_s[Q_W-1];
	assign hue_out        = div_s[Q_W-1].hue_q;
	assign saturation_out = div_s[Q_W-1].sat_q;
	assign value_out      = div_s[Q_W-1].value;

endmodule

// File: hdl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter, 8 bits per channel.
// Input channel: pix_valid/pix_ready with red_in, green_in, blue_in. Output channel:
// hsv_valid/hsv_ready with hue_out, saturation_out, value_out; one result per pixel,
// in order. A transaction moves on a rising edge with valid and ready both high.
// The front stage finds max, min, chroma and the hue sector and forms the two
// division problems; a queue of QUEUE_DEPTH entries follows; the back end is an
// 8-stage restoring divider, one quotient bit per stage, hue and saturation side
// by side, whose last stage is the output register.
// Throughput: one pixel per clock when nothing stalls. An input transaction passes
// the front register, the queue and the 8 divider stages before hsv_valid rises.
// The divider depth is set by the 8-bit quotient.
// If hsv_ready stays low, the result holds steady, the divider stages and the
// queue fill, and pix_ready drops only once all are full; nothing is dropped.
// Reset (arst_n low) empties all stages and the queue; no reset sweep is needed,
// pix_ready is high from the first cycle after reset.
module rgb_to_hsv_converter_core
	import rhc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  logic [CH_W-1:0] red_in,
	input  logic [CH_W-1:0] green_in,
	input  logic [CH_W-1:0] blue_in,
	output logic            hsv_valid,
	input  logic            hsv_ready,
	output logic [Q_W-1:0]  hue_out,
	output logic [Q_W-1:0]  saturation_out,
	output logic [CH_W-1:0] value_out
);

	logic fr_valid;
	logic fr_ready;
	job_t fr_job;
	logic qu_valid;
	logic qu_ready;
	job_t qu_job;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	rhc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_job   (fr_job),
		.pop_valid  (qu_valid),
		.pop_ready  (qu_ready),
		.pop_job    (qu_job)
	);

	rhc_div_pipe u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (qu_valid),
		.job_ready      (qu_ready),
		.job            (qu_job),
		.hsv_valid      (hsv_valid),
		.hsv_ready      (hsv_ready),
		.hue_out        (hue_out),
		.saturation_out (saturation_out),
		.value_out      (value_out)
	);

endmodule

// File: hdl/rhc_checker.sv
module rhc_checker
	import rhc_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            pix_valid,
	input logic            pix_ready,
	input logic [CH_W-1:0] red_in,
	input logic [CH_W-1:0] green_in,
	input logic [CH_W-1:0] blue_in,
	input logic            hsv_valid,
	input logic            hsv_ready,
	input logic [Q_W-1:0]  hue_out,
	input logic [Q_W-1:0]  saturation_out,
	input logic [CH_W-1:0] value_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue_out)
			&& $stable(saturation_out) && $stable(value_out))
		else $error("result changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(red_in)
			&& $stable(green_in) && $stable(blue_in))
		else $error("input transaction changed while waiting");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue_out != 8'hff)
		else $error("hue out of range");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation_out == '0 |-> hue_out == '0)
		else $error("gray pixel with nonzero hue");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !hsv_valid)
		else $error("result valid during reset");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);
